[rtl/deadline_batch_admission_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for deadline_batch_admission
// Wraps the clocking and reset guard shared by all checks in the block.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_BATCH_ADMISSION_ASSERT_SVH
`define DEADLINE_BATCH_ADMISSION_ASSERT_SVH

// condition holds at every edge out of reset
`define DBA_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("deadline_batch_admission: invariant violated");

// consequence holds in the same cycle as the antecedent
`define DBA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deadline_batch_admission: implication violated");

// consequence holds in the cycle after the antecedent
`define DBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deadline_batch_admission: sequence violated");

`endif

[rtl/dba_pkg.sv]
// ----------------------------------------------------------------------------
// dba_pkg
// Types, codes and helper functions for the deadline batch admission block.
// ----------------------------------------------------------------------------
package dba_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_BATCH_DEF   = 16;
    localparam int NUM_EST         = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int DIV_DVS_W       = 12;

    localparam logic [63:0] EST_RESET   = 64'd1000000;
    localparam logic [11:0] NCLK_RESET  = 12'd1000;
    localparam logic [4:0]  MASK_RESET  = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_EST_B1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EST_B2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EST_B4    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EST_B8    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EST_B16   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_CLOCK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DL_OFFSET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SUP_MASK  = 3'd7;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_TRY = 1'b1;
    localparam logic KIND_STRAT = 1'b0;
    localparam logic KIND_TRY   = 1'b1;

    typedef enum logic [2:0] {
        OC_OK       = 3'd0,
        OC_EMPTY    = 3'd1,
        OC_SERVED   = 3'd2,
        OC_UNFILLED = 3'd3,
        OC_BIGGER   = 3'd4,
        OC_LATE     = 3'd5,
        OC_FULL     = 3'd6
    } outcome_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ,
        ST_ENQ_SCAN,
        ST_ENQ_DIV,
        ST_ENQ_EMIT,
        ST_TRY_READ,
        ST_TRY_CMP,
        ST_TRY_RULE1,
        ST_TRY_RULE2,
        ST_TRY_DIV,
        ST_TRY_SUM,
        ST_TRY_LATE,
        ST_TRY_OUT
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] arrival_time;
        logic [63:0] strategy_request_id;
        logic [4:0]  strategy_batch_size;
        logic [63:0] strategy_deadline;
        logic [63:0] free_at;
        logic [11:0] dev_clock;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] req_id;
        logic [4:0]  batch_len;
        logic [63:0] priority_res;
        logic [63:0] deadline;
        outcome_t    outcome;
        logic [63:0] exec_est;
        logic [6:0]  dropped_count;
        logic        last;
    } out_item_t;

    // largest power of two not above min(n, mb, 16); zero maps to zero
    function automatic logic [4:0] eff_size(input logic [15:0] n, input int mb);
        logic [15:0] m;
        logic [4:0]  p;
        m = (n > 16'(mb)) ? 16'(mb) : n;
        p = '0;
        for (int i = 0; i < 5; i++) begin
            if (m >= (16'd1 << i)) begin
                p = 5'd1 << i;
            end
        end
        return p;
    endfunction

    // estimate register index of a power-of-two size
    function automatic logic [2:0] est_index(input logic [4:0] e);
        logic [2:0] k;
        k = '0;
        for (int i = 0; i < 5; i++) begin
            if (e[i]) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

endpackage

[rtl/deadline_batch_admission.sv]
// ----------------------------------------------------------------------------
// deadline_batch_admission
// Per-model request queue with deadline-aware batch admission.
//
//   channel   ports                        role
//   s_        s_valid s_ready s_data       enqueue or try transaction in
//   m_        m_valid m_ready m_data       strategy or try outcome out
//   cfg_      cfg_wr_en cfg_index cfg_wr_data  register writes, no wait
//
// One transaction is in work at a time; s_ready is high only when idle.
// Enqueue: write the deadline, then for each supported batch size divide the estimate
//   by the nominal clock on the shared divider and emit; unsupported sizes are skipped.
// Try: read and compare heads, dropping timed-out ones, until a head survives or the
//   queue runs empty; then apply the rules, divide by the clock if needed, check lateness.
// Reset is synchronous, active low; the ring needs no clearing pass.
// A stalled m_ready holds the block in the emitting state with no loss.
// ----------------------------------------------------------------------------
module deadline_batch_admission import dba_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_BATCH   = MAX_BATCH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // advance a ring slot by n entries, n never above the depth
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] s,
                                               input logic [CW-1:0] n);
        logic [CW:0] t;
        t = (CW+1)'(s) + (CW+1)'(n);
        if (t >= (CW+1)'(QUEUE_DEPTH)) begin
            t = t - (CW+1)'(QUEUE_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // configuration registers
    logic [63:0] est_reg [NUM_EST];
    logic [11:0] nclk_reg;
    logic [63:0] offs_reg;
    logic [4:0]  mask_reg;

    // queue state
    state_t      state_reg, state_next;
    in_item_t    in_reg, in_next;
    logic [63:0] dl_reg, dl_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [63:0] head_id_reg, head_id_next;
    logic [63:0] next_id_reg, next_id_next;
    logic [63:0] id_reg, id_next;
    logic [2:0]  idx_reg, idx_next;
    logic [6:0]  drop_reg, drop_next;
    logic [63:0] ex_reg, ex_next;
    logic        ge_reg, ge_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic [63:0] sum_reg, sum_next;
    logic        carry_reg, carry_next;
    outcome_t    oc_reg, oc_next;
    logic [4:0]  bs_out_reg, bs_out_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    // datapath links
    logic        ring_we, ring_re;
    logic [AW-1:0] ring_waddr;
    logic [63:0] ring_rdata;
    logic        div_start, div_done;
    logic [63:0] div_dvd, div_q;
    logic [11:0] div_dvs;

    logic        out_free;
    logic [4:0]  sz_ok;
    logic [4:0]  eff_bs;
    logic [4:0]  eff_seen;
    logic [CW-1:0] skip_n;

    assign out_free = !m_valid_reg || m_ready;

    // batch sizes that produce a strategy on enqueue
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            sz_ok[i] = mask_reg[i] && ((1 << i) <= MAX_BATCH);
        end
    end

    assign eff_bs   = eff_size(16'(in_reg.strategy_batch_size), MAX_BATCH);
    assign eff_seen = eff_size(16'(seen_reg - CW'(1)), MAX_BATCH);
    assign skip_n   = CW'(in_reg.strategy_request_id - head_id_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_EST; i++) begin
                est_reg[i] <= EST_RESET;
            end
            nclk_reg <= NCLK_RESET;
            offs_reg <= '0;
            mask_reg <= MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_EST_B1:    est_reg[0] <= cfg_wr_data;
                CFG_EST_B2:    est_reg[1] <= cfg_wr_data;
                CFG_EST_B4:    est_reg[2] <= cfg_wr_data;
                CFG_EST_B8:    est_reg[3] <= cfg_wr_data;
                CFG_EST_B16:   est_reg[4] <= cfg_wr_data;
                CFG_NOM_CLOCK: nclk_reg   <= cfg_wr_data[11:0];
                CFG_DL_OFFSET: offs_reg   <= cfg_wr_data;
                CFG_SUP_MASK:  mask_reg   <= cfg_wr_data[4:0];
                default:       mask_reg   <= mask_reg;
            endcase
        end
    end

    // state register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            head_id_reg <= '0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            slot_reg    <= slot_next;
            head_id_reg <= head_id_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        dl_reg     <= dl_next;
        id_reg     <= id_next;
        idx_reg    <= idx_next;
        drop_reg   <= drop_next;
        ex_reg     <= ex_next;
        ge_reg     <= ge_next;
        seen_reg   <= seen_next;
        sum_reg    <= sum_next;
        carry_reg  <= carry_next;
        oc_reg     <= oc_next;
        bs_out_reg <= bs_out_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        dl_next      = dl_reg;
        cnt_next     = cnt_reg;
        slot_next    = slot_reg;
        head_id_next = head_id_reg;
        next_id_next = next_id_reg;
        id_next      = id_reg;
        idx_next     = idx_reg;
        drop_next    = drop_reg;
        ex_next      = ex_reg;
        ge_next      = ge_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        carry_next   = carry_reg;
        oc_next      = oc_reg;
        bs_out_next  = bs_out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ring_we      = 1'b0;
        ring_re      = 1'b0;
        ring_waddr   = slot_add(slot_reg, cnt_reg);
        div_start    = 1'b0;
        div_dvd      = est_reg[idx_reg];
        div_dvs      = (nclk_reg == '0) ? 12'd1 : nclk_reg;
        s_ready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next   = s_data;
                    dl_next   = s_data.arrival_time + offs_reg;
                    drop_next = '0;
                    ex_next   = '0;
                    state_next = (s_data.mode == MODE_ENQ) ? ST_ENQ : ST_TRY_READ;
                end
            end

            ST_ENQ: begin
                if (cnt_reg >= CW'(QUEUE_DEPTH)) begin
                    // queue full: reject, leave the ids alone
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{kind: KIND_STRAT, req_id: next_id_reg,
                                         batch_len: '0, priority_res: '0,
                                         deadline: dl_reg, outcome: OC_FULL,
                                         exec_est: '0, dropped_count: '0,
                                         last: 1'b1};
                        state_next   = ST_IDLE;
                    end
                end else begin
                    ring_we      = 1'b1;
                    cnt_next     = cnt_reg + CW'(1);
                    id_next      = next_id_reg;
                    next_id_next = next_id_reg + 64'd1;
                    idx_next     = '0;
                    state_next   = ST_ENQ_SCAN;
                end
            end

            ST_ENQ_SCAN: begin
                if (idx_reg == 3'(NUM_EST)) begin
                    state_next = ST_IDLE;
                end else if (sz_ok[idx_reg]) begin
                    div_start  = 1'b1;
                    state_next = ST_ENQ_DIV;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end

            ST_ENQ_DIV: begin
                if (div_done) begin
                    ex_next    = div_q;
                    state_next = ST_ENQ_EMIT;
                end
            end

            ST_ENQ_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: KIND_STRAT, req_id: id_reg,
                                     batch_len: 5'd1 << idx_reg,
                                     priority_res: dl_reg - ex_reg,
                                     deadline: dl_reg, outcome: OC_OK,
                                     exec_est: ex_reg, dropped_count: '0,
                                     last: ((sz_ok >> idx_reg) >> 1) == 5'd0};
                    idx_next     = idx_reg + 3'd1;
                    state_next   = ST_ENQ_SCAN;
                end
            end

            ST_TRY_READ: begin
                if (cnt_reg == '0) begin
                    state_next = ST_TRY_RULE1;
                end else begin
                    ring_re    = 1'b1;
                    state_next = ST_TRY_CMP;
                end
            end

            ST_TRY_CMP: begin
                // drop a head whose deadline is before free_at
                if (ring_rdata < in_reg.free_at) begin
                    slot_next    = slot_add(slot_reg, CW'(1));
                    cnt_next     = cnt_reg - CW'(1);
                    head_id_next = head_id_reg + 64'd1;
                    drop_next    = drop_reg + 7'd1;
                    state_next   = ST_TRY_READ;
                end else begin
                    state_next = ST_TRY_RULE1;
                end
            end

            ST_TRY_RULE1: begin
                bs_out_next = '0;
                if (cnt_reg == '0) begin
                    oc_next    = OC_EMPTY;
                    state_next = ST_TRY_OUT;
                end else if (head_id_reg > in_reg.strategy_request_id) begin
                    oc_next    = OC_SERVED;
                    state_next = ST_TRY_OUT;
                end else begin
                    ge_next    = in_reg.strategy_request_id >= next_id_reg;
                    seen_next  = CW'(next_id_reg - in_reg.strategy_request_id);
                    state_next = ST_TRY_RULE2;
                end
            end

            ST_TRY_RULE2: begin
                if (ge_reg || (16'(seen_reg) < 16'(in_reg.strategy_batch_size))) begin
                    oc_next    = OC_UNFILLED;
                    state_next = ST_TRY_OUT;
                end else if (in_reg.strategy_batch_size < eff_seen) begin
                    oc_next    = OC_BIGGER;
                    state_next = ST_TRY_OUT;
                end else if (eff_bs == '0) begin
                    ex_next    = '0;
                    state_next = ST_TRY_SUM;
                end else begin
                    div_start  = 1'b1;
                    div_dvd    = est_reg[est_index(eff_bs)];
                    div_dvs    = (in_reg.dev_clock == '0) ? 12'd1 : in_reg.dev_clock;
                    state_next = ST_TRY_DIV;
                end
            end

            ST_TRY_DIV: begin
                if (div_done) begin
                    ex_next    = div_q;
                    state_next = ST_TRY_SUM;
                end
            end

            ST_TRY_SUM: begin
                {carry_next, sum_next} = {1'b0, in_reg.free_at} + {1'b0, ex_reg};
                state_next = ST_TRY_LATE;
            end

            ST_TRY_LATE: begin
                if (carry_reg || (sum_reg > in_reg.strategy_deadline)) begin
                    oc_next = OC_LATE;
                end else begin
                    // skip requests ahead of the strategy, then pop the batch
                    oc_next      = OC_OK;
                    bs_out_next  = in_reg.strategy_batch_size;
                    cnt_next     = cnt_reg - skip_n - CW'(in_reg.strategy_batch_size);
                    slot_next    = slot_add(slot_reg,
                                            skip_n + CW'(in_reg.strategy_batch_size));
                    head_id_next = head_id_reg + 64'(skip_n)
                                 + 64'(in_reg.strategy_batch_size);
                    drop_next    = drop_reg + 7'(skip_n);
                end
                state_next = ST_TRY_OUT;
            end

            ST_TRY_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: KIND_TRY,
                                     req_id: in_reg.strategy_request_id,
                                     batch_len: bs_out_reg, priority_res: '0,
                                     deadline: in_reg.strategy_deadline,
                                     outcome: oc_reg, exec_est: ex_reg,
                                     dropped_count: drop_reg, last: 1'b1};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    dba_ring #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (dl_reg),
        .rd_en   (ring_re),
        .rd_addr (slot_reg),
        .rd_data (ring_rdata)
    );

    dba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "deadline_batch_admission_assert.svh"

    `DBA_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(QUEUE_DEPTH))
    `DBA_ASSERT_ALWAYS(a_id_span, (next_id_reg - head_id_reg) == 64'(cnt_reg))
    `DBA_ASSERT_IMPLIES(a_strat_pow2, m_valid_reg && m_data_reg.kind == KIND_STRAT && m_data_reg.outcome == OC_OK, $onehot(m_data_reg.batch_len))
    `DBA_ASSERT_NEXT(a_read_cmp, state_reg == ST_TRY_READ && cnt_reg != '0, state_reg == ST_TRY_CMP)

endmodule

[rtl/dba_div.sv]
// ----------------------------------------------------------------------------
// dba_div
// Iterative 64 by 12 bit unsigned divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module dba_div import dba_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [63:0]          dividend,
    input  logic [DIV_DVS_W-1:0] divisor,
    output logic [63:0]          quotient,
    output logic                 done
);

    logic [63:0]          q_reg, q_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [3:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // four restoring steps on the narrow remainder
    always_comb begin
        logic [DIV_DVS_W:0] t;
        q_next   = q_reg;
        rem_next = rem_reg;
        for (int j = 0; j < 4; j++) begin
            t      = {rem_next, q_next[63]};
            q_next = {q_next[62:0], 1'b0};
            if (t >= {1'b0, dvs_reg}) begin
                t         = t - {1'b0, dvs_reg};
                q_next[0] = 1'b1;
            end
            rem_next = t[DIV_DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

[rtl/dba_ring.sv]
// ----------------------------------------------------------------------------
// dba_ring
// Deadline ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dba_ring import dba_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(QUEUE_DEPTH_DEF)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[test/dba_checker.sv]
// ----------------------------------------------------------------------------
// dba_checker
// Watches the register port and both channels of the admission block, keeps
// its own copy of the queue and registers, predicts every result and compares.
// ----------------------------------------------------------------------------
module dba_checker import dba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    fail_count,
    output int                    pending,
    output int                    result_count,
    output logic [63:0]           hint_next_id,
    output logic [63:0]           hint_head_id
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    logic [63:0] est_reg [NUM_EST];
    logic [11:0] nom_clock;
    logic [63:0] dl_offset;
    logic [4:0]  size_mask;

    logic [63:0] next_id;
    logic [63:0] head_id;
    int          queued;
    logic [5:0]  head_slot;
    logic [63:0] deadline_ring [DEPTH];

    out_item_t   expected_results [$];
    int          mismatches;
    int          results_seen;

    initial begin
        fail_count   = 0;
        pending      = 0;
        result_count = 0;
        hint_next_id = '0;
        hint_head_id = '0;
    end

    function automatic logic [63:0] floor_pow2(input logic [63:0] n);
        logic [63:0] p;
        p = 64'd1;
        if (n == 0) return 64'd0;
        while (p * 2 <= n && p * 2 <= 64'd16) p = p * 2;
        return p;
    endfunction

    function automatic logic [63:0] batch_estimate(input logic [63:0] size,
                                                   input logic [11:0] clk);
        logic [63:0] e;
        int          k;
        logic [63:0] d;
        e = floor_pow2(size);
        k = 0;
        if (e == 0) return 64'd0;
        while (k < 4 && (64'd1 << k) < e) k++;
        d = (clk == 0) ? 64'd1 : 64'(clk);
        return est_reg[k] / d;
    endfunction

    task automatic pop_head();
        head_slot = head_slot + 6'd1;
        queued    = queued - 1;
        head_id   = head_id + 64'd1;
    endtask

    task automatic predict_admission(input in_item_t it);
        out_item_t   r;
        logic [63:0] dl;
        logic [63:0] ex;
        logic [63:0] done_at;
        logic [63:0] bs;
        logic [6:0]  dropped;
        int          n;
        r = '0;
        if (it.mode == MODE_ENQ) begin
            dl = it.arrival_time + dl_offset;
            if (queued >= DEPTH) begin
                r.kind = KIND_STRAT;
                r.req_id = next_id;
                r.deadline = dl;
                r.outcome = OC_FULL;
                r.last = 1'b1;
                expected_results = {expected_results, r};
                return;
            end
            deadline_ring[6'(head_slot + 6'(queued))] = dl;
            queued++;
            n = 0;
            for (int i = 0; i < 5; i++) begin
                if (size_mask[i]) begin
                    ex = batch_estimate(64'd1 << i, nom_clock);
                    r = '0;
                    r.kind = KIND_STRAT;
                    r.req_id = next_id;
                    r.batch_len = 5'd1 << i;
                    r.priority_res = dl - ex;
                    r.deadline = dl;
                    r.outcome = OC_OK;
                    r.exec_est = ex;
                    expected_results = {expected_results, r};
                    n++;
                end
            end
            if (n > 0) expected_results[expected_results.size() - 1].last = 1'b1;
            next_id = next_id + 64'd1;
        end else begin
            bs = 64'(it.strategy_batch_size);
            dropped = '0;
            while (queued > 0 && deadline_ring[head_slot] < it.free_at) begin
                pop_head();
                dropped++;
            end
            r.kind = KIND_TRY;
            r.req_id = it.strategy_request_id;
            r.deadline = it.strategy_deadline;
            r.last = 1'b1;
            if (queued == 0) begin
                r.outcome = OC_EMPTY;
            end else if (head_id > it.strategy_request_id) begin
                r.outcome = OC_SERVED;
            end else if (it.strategy_request_id >= next_id ||
                         next_id - it.strategy_request_id < bs) begin
                r.outcome = OC_UNFILLED;
            end else if (bs < floor_pow2(next_id - it.strategy_request_id - 1)) begin
                r.outcome = OC_BIGGER;
            end else begin
                ex = batch_estimate(bs, it.dev_clock);
                done_at = it.free_at + ex;
                r.exec_est = ex;
                if (done_at < it.free_at || done_at > it.strategy_deadline) begin
                    r.outcome = OC_LATE;
                end else begin
                    // skip the requests queued ahead of the strategy's own
                    while (head_id < it.strategy_request_id && queued > 0) begin
                        pop_head();
                        dropped++;
                    end
                    for (logic [63:0] k = 0; k < bs && queued > 0; k++) pop_head();
                    r.outcome = OC_OK;
                    r.batch_len = it.strategy_batch_size;
                end
            end
            r.dropped_count = dropped;
            expected_results = {expected_results, r};
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        bit        bad;
        results_seen++;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t unexpected result: kind %0d id %0d outcome %0d",
                         $realtime, got.kind, got.req_id, got.outcome);
            return;
        end
        want = expected_results.pop_front();
        bad = (got.kind != want.kind) || (got.req_id != want.req_id) ||
              (got.batch_len != want.batch_len) ||
              (got.priority_res != want.priority_res) ||
              (got.deadline != want.deadline) || (got.outcome != want.outcome) ||
              (got.exec_est != want.exec_est) ||
              (got.dropped_count != want.dropped_count) || (got.last != want.last);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t mismatch exp: k%0d id %0h bs %0d pr %0h dl %0h oc %0d ex %0h dr %0d l%0d",
                         $realtime, want.kind, want.req_id, want.batch_len,
                         want.priority_res, want.deadline, want.outcome,
                         want.exec_est, want.dropped_count, want.last);
                $display("%t          got: k%0d id %0h bs %0d pr %0h dl %0h oc %0d ex %0h dr %0d l%0d",
                         $realtime, got.kind, got.req_id, got.batch_len,
                         got.priority_res, got.deadline, got.outcome,
                         got.exec_est, got.dropped_count, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_EST; i++) est_reg[i] = EST_RESET;
            nom_clock = NCLK_RESET;
            dl_offset = '0;
            size_mask = MASK_RESET;
            next_id   = '0;
            head_id   = '0;
            queued    = 0;
            head_slot = '0;
            expected_results.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NOM_CLOCK: nom_clock = cfg_wr_data[11:0];
                    CFG_DL_OFFSET: dl_offset = cfg_wr_data;
                    CFG_SUP_MASK:  size_mask = cfg_wr_data[4:0];
                    default:       est_reg[cfg_index] = cfg_wr_data;
                endcase
            end
            if (m_valid && m_ready) compare_result(m_data);
            if (s_valid && s_ready) predict_admission(s_data);
        end
        fail_count   <= mismatches;
        pending      <= expected_results.size();
        result_count <= results_seen;
        hint_next_id <= next_id;
        hint_head_id <= head_id;
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Regression for deadline_batch_admission: directed enqueue/try corner cases,
// then random request traffic over several register settings with bursty
// sending and stalling results; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import dba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_ITEMS    = 75;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int          fail_count;
    int          pending;
    int          result_count;
    logic [63:0] hint_next_id;
    logic [63:0] hint_head_id;

    int          burst_left = 0;
    int          sent_enq   = 0;
    int          sent_try   = 0;
    int          idle_cycles = 0;
    logic [63:0] tnow = 64'd1000;

    deadline_batch_admission uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    dba_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .hint_next_id (hint_next_id),
        .hint_head_id (hint_head_id)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Receiver: switch among stall styles chosen at random (always ready, coin flip,
    // fixed ready pattern, mostly stalled).
    int rx_style = 0;
    int rx_cycle = 0;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 63) rx_style <= $urandom_range(0, 3);
        case (rx_style)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (rx_cycle % 5) < 3;
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: count cycles without any transaction on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Build an enqueue; the try-only fields carry noise.
    function automatic in_item_t make_enqueue(input logic [63:0] arrival);
        in_item_t it;
        it.mode                = MODE_ENQ;
        it.arrival_time        = arrival;
        it.strategy_request_id = rand64();
        it.strategy_batch_size = 5'($urandom);
        it.strategy_deadline   = rand64();
        it.free_at             = rand64();
        it.dev_clock           = 12'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_try(input logic [63:0] req, input logic [4:0] bs,
                                          input logic [63:0] dl, input logic [63:0] fa,
                                          input logic [11:0] clk);
        in_item_t it;
        it.mode                = MODE_TRY;
        it.arrival_time        = rand64();
        it.strategy_request_id = req;
        it.strategy_batch_size = bs;
        it.strategy_deadline   = dl;
        it.free_at             = fa;
        it.dev_clock           = clk;
        return it;
    endfunction

    // Present one transaction and hold it until accepted; open a new burst
    // (with a random gap before it) when the current one runs out.
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (it.mode == MODE_ENQ) sent_enq++;
        else sent_try++;
    endtask

    // Hold off until every expected result has come, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int phase);
        logic [63:0] v [8];
        for (int i = 0; i < NUM_EST; i++) v[i] = EST_RESET;
        v[CFG_NOM_CLOCK] = 64'(NCLK_RESET);
        v[CFG_DL_OFFSET] = 64'd0;
        v[CFG_SUP_MASK]  = 64'(MASK_RESET);
        case (phase)
            1: begin
                for (int i = 0; i < NUM_EST; i++) v[i] = $urandom_range(1000, 5000000);
                v[CFG_NOM_CLOCK] = $urandom_range(1, 4095);
                v[CFG_DL_OFFSET] = 64'd5000;
            end
            2: begin
                for (int i = 0; i < NUM_EST; i++) v[i] = 64'd0;
                v[CFG_NOM_CLOCK] = 64'd1;
                v[CFG_SUP_MASK]  = 64'h15;
            end
            3: begin
                // all-ones estimates at clock 1 push completions past 2^64
                for (int i = 0; i < NUM_EST; i++) v[i] = '1;
                v[CFG_NOM_CLOCK] = 64'd1;
                v[CFG_DL_OFFSET] = '1;
            end
            4: begin
                for (int i = 0; i < NUM_EST; i++) v[i] = rand64();
                v[CFG_NOM_CLOCK] = 64'd4095;
                v[CFG_DL_OFFSET] = rand64();
                v[CFG_SUP_MASK]  = 64'd0;
            end
            5: begin
                for (int i = 0; i < NUM_EST; i++) v[i] = rand64() >> $urandom_range(0, 63);
                v[CFG_NOM_CLOCK] = $urandom_range(1, 4095);
                v[CFG_DL_OFFSET] = rand64() >> $urandom_range(0, 63);
                v[CFG_SUP_MASK]  = $urandom_range(1, 31);
            end
            6: begin
                v[CFG_DL_OFFSET] = 64'd3000;
                v[CFG_SUP_MASK]  = 64'h03;
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= CFG_IDX_W'(i);
            cfg_wr_data <= v[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Directed pass at reset settings: ids 0.. issued in order from here.
    task automatic run_directed();
        send_item(make_try(64'd0, 5'd1, '1, 64'd0, 12'd1000));       // empty queue
        for (int i = 0; i < 4; i++) send_item(make_enqueue(64'd1000 + 100 * i));
        send_item(make_try(64'd0, 5'd8, '1, 64'd0, 12'd1000));       // batch not filled
        send_item(make_try(64'd5, 5'd1, '1, 64'd0, 12'd1000));       // id never issued
        send_item(make_try(64'd0, 5'd1, '1, 64'd0, 12'd1000));       // larger batch coming
        send_item(make_try(64'd0, 5'd4, 64'd0, 64'd0, 12'd1000));    // deadline missed
        send_item(make_enqueue(64'hFFFF_FFFF_FFFF_FF00));             // id 4
        // drop the four early heads, completion wraps past 2^64
        send_item(make_try(64'd4, 5'd1, '1, 64'hFFFF_FFFF_FFFF_FF00, 12'd1));
        send_item(make_try(64'd4, 5'd1, '1, 64'd0, 12'd0));          // zero clock, accept
        send_item(make_try(64'd2, 5'd1, '1, 64'd0, 12'd1000));       // empty again
        send_item(make_enqueue(64'd2000));                            // id 5
        send_item(make_enqueue(64'd2000));                            // id 6
        send_item(make_try(64'd3, 5'd1, '1, 64'd0, 12'd4095));       // already served
        send_item(make_try(64'd6, 5'd1, '1, 64'd0, 12'd4095));       // skip id 5, accept
        for (int i = 0; i < 3; i++) send_item(make_enqueue(64'd3000)); // ids 7..9
        send_item(make_try(64'd7, 5'd3, '1, 64'd0, 12'd77));         // odd size accepted
        send_item(make_enqueue('1));                                  // id 10
        send_item(make_try(64'd10, 5'd31, '1, 64'd0, 12'd1000));     // odd size unfilled
        send_item(make_try(64'd10, 5'd0, '1, 64'd0, 12'd1000));      // size zero accepted
    endtask

    // Mostly well-formed traffic around the live queue, with some noise.
    task automatic run_random(input int phase);
        int          pick;
        int          enq_pct;
        logic [63:0] span;
        logic [63:0] req;
        logic [63:0] fa;
        logic [63:0] dl;
        logic [4:0]  bs;
        logic [11:0] clk;
        enq_pct = (phase == 6) ? 80 : 45;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) drain();
            tnow = tnow + $urandom_range(0, 200);
            pick = $urandom_range(0, 99);
            if (pick < enq_pct) begin
                send_item(make_enqueue(tnow));
            end else if (pick < 92) begin
                span = hint_next_id - hint_head_id;
                req  = hint_head_id + $urandom_range(0, 32'(span > 40 ? 40 : span));
                if ($urandom_range(0, 9) == 0) req = hint_head_id - $urandom_range(1, 4);
                bs   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'd1 << $urandom_range(0, 4);
                fa   = tnow - $urandom_range(0, 8000);
                dl   = ($urandom_range(0, 4) == 0) ? '1 : fa + $urandom_range(0, 6000);
                clk  = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
                send_item(make_try(req, bs, dl, fa, clk));
            end else begin
                send_item(make_try(rand64(), 5'($urandom), rand64(), rand64(), 12'($urandom)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        configure(0);
        run_directed();
        for (int p = 1; p < NUM_PHASES; p++) begin
            drain();
            configure(p);
            run_random(p);
        end
        drain();
        $display("covered %0d enqueue and %0d try transactions, %0d results checked,",
                 sent_enq, sent_try, result_count);
        $display("over %0d register settings including extreme estimates and offsets",
                 NUM_PHASES);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dba_pkg.sv
rtl/dba_div.sv
rtl/dba_ring.sv
rtl/deadline_batch_admission.sv
test/dba_checker.sv
test/tb.sv
